@@ src/ist_pkg.sv @@
// shared constants, codes and controller/datapath interface types
package ist_pkg;

    localparam int WIN    = 16;
    localparam int IDX_W  = $clog2(WIN);
    localparam int TOT_W  = $clog2(WIN + 1);
    localparam int SMP_W  = 12;
    localparam int T_W    = 32;
    localparam int CFG_W  = 20;
    localparam int CIDX_W = 3;
    localparam int ACC_W  = 32;
    localparam int ACNT_W = 20;
    localparam int SKIP_W = 4;

    localparam logic [CIDX_W-1:0] CFG_SAT  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_TGT  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_PER  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TMO  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_STL  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_SKIP = 3'd5;

    localparam logic [1:0] PH_RUN = 2'd0;
    localparam logic [1:0] PH_DIS = 2'd1;
    localparam logic [1:0] PH_SET = 2'd2;

    localparam logic [ACNT_W-1:0] COUNT_MAX = '1;

    // regression sum widths
    localparam int S_W    = T_W + IDX_W;
    localparam int V_W    = SMP_W + IDX_W;
    localparam int RV_W   = T_W + SMP_W;
    localparam int P_W    = RV_W + IDX_W;
    localparam int RR_W   = 2 * T_W;
    localparam int Q_W    = RR_W + IDX_W;
    localparam int NQ_W   = Q_W + TOT_W;
    localparam int SS_W   = 2 * S_W;
    localparam int NP_W   = P_W + TOT_W;
    localparam int SV_W   = S_W + V_W;
    localparam int MAG_W  = (NP_W > SV_W) ? NP_W : SV_W;
    localparam int SCL_W  = 28;
    localparam logic [SCL_W-1:0] SCALE = 28'd256000000;
    localparam int NUM_W  = MAG_W + SCL_W;
    localparam int DEN_W  = NQ_W;

    // serial multiplier and divider sizes
    localparam int MA_W   = Q_W;
    localparam int MB_W   = S_W;
    localparam int MP_W   = MA_W + MB_W;
    localparam int MC_W   = $clog2(MB_W);
    localparam int DVD_W  = NUM_W;
    localparam int DVS_W  = DEN_W;
    localparam int DC_W   = $clog2(DVD_W);

    localparam int RAM_W  = T_W + SMP_W;

    localparam int ID_W   = 48;
    localparam int OD_BITS = 3 + 32 + TOT_W + 1 + SMP_W + 32 + 1 + SMP_W;
    localparam int OD_W   = ((OD_BITS + 7) / 8) * 8;

    localparam int MS_W = 3;
    localparam logic [MS_W-1:0] MS_NQ = 3'd0;
    localparam logic [MS_W-1:0] MS_SS = 3'd1;
    localparam logic [MS_W-1:0] MS_NP = 3'd2;
    localparam logic [MS_W-1:0] MS_SV = 3'd3;
    localparam logic [MS_W-1:0] MS_SC = 3'd4;

    typedef struct packed {
        logic            load;
        logic            eval;
        logic            div_start;
        logic            div_slope;
        logic            skip_dec;
        logic            store;
        logic            slope_zero;
        logic            tref_rd;
        logic            tref_lat;
        logic            pt_rd;
        logic            pt_mul;
        logic            pt_acc;
        logic            mul_start;
        logic [MS_W-1:0] mul_sel;
        logic            den_calc;
        logic            mag_calc;
        logic            out_load;
    } t_cmd;

    typedef struct packed {
        logic point_due;
        logic skip_nz;
        logic few;
        logic loop_last;
        logic den_zero;
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

@@ src/ist_ram.sv @@
// generic single write port ram with registered read
module ist_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/ist_mul.sv @@
// shift-add multiplier, one multiplier bit per cycle
module ist_mul import ist_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MA_W-1:0] i_a,
    input  logic [MB_W-1:0] i_b,
    output logic            o_done,
    output logic [MP_W-1:0] o_p
);
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [MC_W-1:0] r_cnt, n_cnt;
    logic [MP_W-1:0] r_a, n_a;
    logic [MB_W-1:0] r_b, n_b;
    logic [MP_W-1:0] r_p, n_p;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_p    = r_p;
        if (i_start) begin
            n_a    = MP_W'(i_a);
            n_b    = i_b;
            n_p    = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_p = r_p + r_a;
            end
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == MC_W'(MB_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_p   <= n_p;
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

@@ src/ist_div.sv @@
// restoring divider, one quotient bit per cycle
module ist_div import ist_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo
);
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DC_W-1:0]  r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_d, n_d;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_start) begin
            n_q    = i_dvd;
            n_d    = i_dvs;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? DVS_W'(w_trial - {1'b0, r_d}) : w_trial[DVS_W-1:0];
            n_q   = {r_q[DVD_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DC_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

@@ src/ist_dp.sv @@
// datapath: tracker state, point ring, regression sums and output register
module ist_dp import ist_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [ID_W-1:0]   i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [OD_W-1:0]   o_m_tdata
);
    // configuration
    logic [SMP_W-1:0]  r_sat, n_sat;
    logic [SMP_W-1:0]  r_tgt, n_tgt;
    logic [CFG_W-1:0]  r_per, n_per;
    logic [CFG_W-1:0]  r_tmo, n_tmo;
    logic [CFG_W-1:0]  r_stl, n_stl;
    logic [SKIP_W-1:0] r_skp_cfg, n_skp_cfg;

    // latched request
    logic              r_func, n_func;
    logic [SMP_W-1:0]  r_smp, n_smp;
    logic [T_W-1:0]    r_time, n_time;
    logic              r_ceil, n_ceil;

    // tracker state
    logic [1:0]        r_phase, n_phase;
    logic [T_W-1:0]    r_pst, n_pst;
    logic              r_pend, n_pend;
    logic [ACC_W-1:0]  r_sum, n_sum;
    logic [ACNT_W-1:0] r_cnt, n_cnt;
    logic [T_W-1:0]    r_ast, n_ast;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [IDX_W-1:0]  r_wi, n_wi;
    logic [SKIP_W-1:0] r_skip, n_skip;
    logic [31:0]       r_slope, n_slope;
    logic [SMP_W-1:0]  r_last, n_last;
    logic [SMP_W-1:0]  r_trip, n_trip;
    logic [31:0]       r_rcnt, n_rcnt;
    logic              r_stuck, n_stuck;
    logic              r_ev, n_ev;
    logic              r_npf, n_npf;
    logic              r_ovalid, n_ovalid;
    logic [MS_W-1:0]   r_msel, n_msel;
    logic              r_dsel, n_dsel;

    // point and regression working registers
    logic [ACC_W-1:0]  r_dsum, n_dsum;
    logic [ACNT_W-1:0] r_dcnt, n_dcnt;
    logic [SMP_W-1:0]  r_mean, n_mean;
    logic [T_W-1:0]    r_tref, n_tref;
    logic [TOT_W-1:0]  r_i, n_i;
    logic [T_W-1:0]    r_r, n_r;
    logic [SMP_W-1:0]  r_v, n_v;
    logic [RV_W-1:0]   r_rv, n_rv;
    logic [RR_W-1:0]   r_rr, n_rr;
    logic [S_W-1:0]    r_s, n_s;
    logic [V_W-1:0]    r_vs, n_vs;
    logic [P_W-1:0]    r_p, n_p;
    logic [Q_W-1:0]    r_q, n_q;
    logic [NQ_W-1:0]   r_nq, n_nq;
    logic [SS_W-1:0]   r_ss, n_ss;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [NP_W-1:0]   r_np, n_np;
    logic [SV_W-1:0]   r_sv, n_sv;
    logic [MAG_W-1:0]  r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [OD_W-1:0]   r_odata, n_odata;

    // step helpers
    logic [T_W-1:0]    w_start;
    logic              w_full;
    logic [ACC_W-1:0]  w_sum1;
    logic [ACNT_W-1:0] w_cnt1;
    logic              w_due;
    logic              w_trig;
    logic              w_tmo;
    logic              w_low;
    logic              w_rel;
    logic [T_W-1:0]    w_pst_mid;
    logic              w_settled;
    logic [T_W-1:0]    w_r;

    logic              w_ram_we;
    logic [IDX_W-1:0]  w_raddr;
    logic [RAM_W-1:0]  w_rdata;
    logic [T_W-1:0]    w_rd_t;
    logic [SMP_W-1:0]  w_rd_v;

    logic [MA_W-1:0]   w_ma;
    logic [MB_W-1:0]   w_mb;
    logic              w_mdone;
    logic [MP_W-1:0]   w_prod;
    logic [DVD_W-1:0]  w_dvd;
    logic [DVS_W-1:0]  w_dvs;
    logic              w_ddone;
    logic [DVD_W-1:0]  w_quo;
    logic [31:0]       w_lim;
    logic [31:0]       w_mag32;

    assign w_start  = r_pend ? r_time : r_ast;
    assign w_full   = r_cnt == COUNT_MAX;
    assign w_sum1   = w_full ? r_sum : r_sum + ACC_W'(r_smp);
    assign w_cnt1   = w_full ? r_cnt : r_cnt + 1'b1;
    assign w_due    = (r_time - w_start) >= T_W'(r_per);
    assign w_trig   = (r_smp >= r_sat) || r_ceil;
    assign w_tmo    = (r_phase == PH_DIS) && ((r_time - r_pst) >= T_W'(r_tmo));
    assign w_low    = (r_phase == PH_DIS) && !r_func && (r_smp <= r_tgt);
    assign w_rel    = w_tmo || w_low;
    assign w_pst_mid = w_rel ? r_time : r_pst;
    assign w_settled = (w_rel || r_phase == PH_SET)
                       && ((r_time - w_pst_mid) >= T_W'(r_stl));

    assign w_rd_t   = w_rdata[RAM_W-1:SMP_W];
    assign w_rd_v   = w_rdata[SMP_W-1:0];
    assign w_r      = w_rd_t - r_tref;
    assign w_ram_we = i_cmd.store;
    // the oldest point sits at slot zero until the ring wraps
    assign w_raddr  = i_cmd.tref_rd ? ((r_total < TOT_W'(WIN)) ? '0 : r_wi)
                                    : r_i[IDX_W-1:0];

    always_comb begin
        case (i_cmd.mul_sel)
            MS_NQ: begin
                w_ma = MA_W'(r_q);
                w_mb = MB_W'(r_total);
            end
            MS_SS: begin
                w_ma = MA_W'(r_s);
                w_mb = MB_W'(r_s);
            end
            MS_NP: begin
                w_ma = MA_W'(r_p);
                w_mb = MB_W'(r_total);
            end
            MS_SV: begin
                w_ma = MA_W'(r_s);
                w_mb = MB_W'(r_vs);
            end
            default: begin
                w_ma = MA_W'(r_mag);
                w_mb = MB_W'(SCALE);
            end
        endcase
    end

    assign w_dvd = i_cmd.div_slope ? DVD_W'(r_num) : DVD_W'(r_dsum);
    assign w_dvs = i_cmd.div_slope ? DVS_W'(r_den) : DVS_W'(r_dcnt);

    assign w_lim   = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign w_mag32 = ((|w_quo[DVD_W-1:32]) || (w_quo[31:0] > w_lim)) ? w_lim : w_quo[31:0];

    ist_ram #(.W(RAM_W), .D(WIN)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wi),
        .i_wdata ({r_time, r_mean}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ist_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_prod)
    );

    ist_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_sat = r_sat;   n_tgt = r_tgt;   n_per = r_per;
        n_tmo = r_tmo;   n_stl = r_stl;   n_skp_cfg = r_skp_cfg;
        n_func = r_func; n_smp = r_smp;   n_time = r_time; n_ceil = r_ceil;
        n_phase = r_phase; n_pst = r_pst; n_pend = r_pend;
        n_sum = r_sum;   n_cnt = r_cnt;   n_ast = r_ast;
        n_total = r_total; n_wi = r_wi;   n_skip = r_skip;
        n_slope = r_slope; n_last = r_last; n_trip = r_trip;
        n_rcnt = r_rcnt; n_stuck = r_stuck; n_ev = r_ev; n_npf = r_npf;
        n_msel = r_msel; n_dsel = r_dsel;
        n_dsum = r_dsum; n_dcnt = r_dcnt; n_mean = r_mean;
        n_tref = r_tref; n_i = r_i; n_r = r_r; n_v = r_v;
        n_rv = r_rv; n_rr = r_rr; n_s = r_s; n_vs = r_vs; n_p = r_p; n_q = r_q;
        n_nq = r_nq; n_ss = r_ss; n_den = r_den; n_np = r_np; n_sv = r_sv;
        n_mag = r_mag; n_neg = r_neg; n_num = r_num; n_odata = r_odata;
        n_ovalid = r_ovalid;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAT:  n_sat     = i_cfg_data[SMP_W-1:0];
                CFG_TGT:  n_tgt     = i_cfg_data[SMP_W-1:0];
                CFG_PER:  n_per     = i_cfg_data;
                CFG_TMO:  n_tmo     = i_cfg_data;
                CFG_STL:  n_stl     = i_cfg_data;
                CFG_SKIP: n_skp_cfg = i_cfg_data[SKIP_W-1:0];
                default: ;
            endcase
        end

        if (i_cmd.load) begin
            n_func = i_s_tuser;
            n_smp  = i_s_tdata[SMP_W-1:0];
            n_time = i_s_tdata[SMP_W+T_W-1:SMP_W];
            n_ceil = i_s_tdata[SMP_W+T_W];
        end

        if (i_cmd.eval) begin
            n_ev  = 1'b0;
            n_npf = 1'b0;
            if (r_phase == PH_DIS || r_phase == PH_SET) begin
                if (w_rel) begin
                    n_stuck = w_tmo;
                    n_phase = PH_SET;
                    n_pst   = r_time;
                end
                if (w_settled) begin
                    n_total = '0;
                    n_wi    = '0;
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_ast   = r_time;
                    n_pend  = 1'b0;
                    n_skip  = r_skp_cfg;
                    n_phase = PH_RUN;
                end
            end else if (r_func) begin
                n_trip  = r_last;
                n_phase = PH_DIS;
                n_pst   = r_time;
                n_rcnt  = r_rcnt + 1'b1;
                n_ev    = 1'b1;
            end else begin
                n_last = r_smp;
                n_pend = 1'b0;
                if (w_due) begin
                    n_dsum = w_sum1;
                    n_dcnt = w_cnt1;
                    n_sum  = '0;
                    n_cnt  = '0;
                    n_ast  = r_time;
                end else begin
                    n_sum = w_sum1;
                    n_cnt = w_cnt1;
                    n_ast = w_start;
                end
                // a saturating sample still counts toward the point
                if (w_trig) begin
                    n_trip  = r_smp;
                    n_phase = PH_DIS;
                    n_pst   = r_time;
                    n_rcnt  = r_rcnt + 1'b1;
                    n_ev    = 1'b1;
                end
            end
        end

        if (i_cmd.skip_dec) begin
            n_skip = r_skip - 1'b1;
        end
        if (i_cmd.store) begin
            n_wi  = (r_wi == IDX_W'(WIN - 1)) ? '0 : r_wi + 1'b1;
            if (r_total < TOT_W'(WIN)) begin
                n_total = r_total + 1'b1;
            end
            n_npf = 1'b1;
        end
        if (i_cmd.slope_zero) begin
            n_slope = '0;
        end
        if (i_cmd.tref_lat) begin
            n_tref = w_rd_t;
            n_i    = '0;
            n_s    = '0;
            n_vs   = '0;
            n_p    = '0;
            n_q    = '0;
        end
        if (i_cmd.pt_mul) begin
            n_r  = w_r;
            n_v  = w_rd_v;
            n_rr = w_r * w_r;
            n_rv = w_r * w_rd_v;
        end
        if (i_cmd.pt_acc) begin
            n_s  = r_s + S_W'(r_r);
            n_vs = r_vs + V_W'(r_v);
            n_p  = r_p + P_W'(r_rv);
            n_q  = r_q + Q_W'(r_rr);
            n_i  = r_i + 1'b1;
        end
        if (i_cmd.mul_start) begin
            n_msel = i_cmd.mul_sel;
        end
        if (w_mdone) begin
            case (r_msel)
                MS_NQ:   n_nq  = w_prod[NQ_W-1:0];
                MS_SS:   n_ss  = w_prod[SS_W-1:0];
                MS_NP:   n_np  = w_prod[NP_W-1:0];
                MS_SV:   n_sv  = w_prod[SV_W-1:0];
                default: n_num = w_prod[NUM_W-1:0];
            endcase
        end
        if (i_cmd.den_calc) begin
            n_den = r_nq - NQ_W'(r_ss);
        end
        if (i_cmd.mag_calc) begin
            n_neg = MAG_W'(r_np) < MAG_W'(r_sv);
            n_mag = n_neg ? MAG_W'(r_sv) - MAG_W'(r_np) : MAG_W'(r_np) - MAG_W'(r_sv);
        end
        if (i_cmd.div_start) begin
            n_dsel = i_cmd.div_slope;
        end
        if (w_ddone) begin
            if (r_dsel) begin
                n_slope = r_neg ? 32'd0 - w_mag32 : w_mag32;
            end else begin
                n_mean = w_quo[SMP_W-1:0];
            end
        end

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end
        if (i_cmd.out_load) begin
            n_ovalid = 1'b1;
            n_odata  = OD_W'({r_last, r_stuck, r_rcnt, r_trip, r_ev, r_total, r_slope,
                              r_npf, r_phase == PH_SET, r_phase == PH_DIS});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat     <= '1;
            r_tgt     <= 12'd620;
            r_per     <= 20'd20000;
            r_tmo     <= 20'd50000;
            r_stl     <= 20'd20000;
            r_skp_cfg <= 4'd2;
            r_phase   <= PH_RUN;
            r_pst     <= '0;
            r_pend    <= 1'b1;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_ast     <= '0;
            r_total   <= '0;
            r_wi      <= '0;
            r_skip    <= 4'd2;
            r_slope   <= '0;
            r_last    <= '0;
            r_trip    <= '0;
            r_rcnt    <= '0;
            r_stuck   <= 1'b0;
            r_ev      <= 1'b0;
            r_npf     <= 1'b0;
            r_ovalid  <= 1'b0;
            r_msel    <= MS_NQ;
            r_dsel    <= 1'b0;
        end else begin
            r_sat     <= n_sat;
            r_tgt     <= n_tgt;
            r_per     <= n_per;
            r_tmo     <= n_tmo;
            r_stl     <= n_stl;
            r_skp_cfg <= n_skp_cfg;
            r_phase   <= n_phase;
            r_pst     <= n_pst;
            r_pend    <= n_pend;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_ast     <= n_ast;
            r_total   <= n_total;
            r_wi      <= n_wi;
            r_skip    <= n_skip;
            r_slope   <= n_slope;
            r_last    <= n_last;
            r_trip    <= n_trip;
            r_rcnt    <= n_rcnt;
            r_stuck   <= n_stuck;
            r_ev      <= n_ev;
            r_npf     <= n_npf;
            r_ovalid  <= n_ovalid;
            r_msel    <= n_msel;
            r_dsel    <= n_dsel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_smp   <= n_smp;
        r_time  <= n_time;
        r_ceil  <= n_ceil;
        r_dsum  <= n_dsum;
        r_dcnt  <= n_dcnt;
        r_mean  <= n_mean;
        r_tref  <= n_tref;
        r_i     <= n_i;
        r_r     <= n_r;
        r_v     <= n_v;
        r_rv    <= n_rv;
        r_rr    <= n_rr;
        r_s     <= n_s;
        r_vs    <= n_vs;
        r_p     <= n_p;
        r_q     <= n_q;
        r_nq    <= n_nq;
        r_ss    <= n_ss;
        r_den   <= n_den;
        r_np    <= n_np;
        r_sv    <= n_sv;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_num   <= n_num;
        r_odata <= n_odata;
    end

    assign o_stat.point_due = (r_phase == PH_RUN) && !r_func && w_due;
    assign o_stat.skip_nz   = r_skip != '0;
    assign o_stat.few       = r_total < TOT_W'(2);
    assign o_stat.loop_last = r_i == (r_total - 1'b1);
    assign o_stat.den_zero  = r_den == '0;
    assign o_stat.mul_done  = w_mdone;
    assign o_stat.div_done  = w_ddone;
    assign o_stat.out_free  = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOT_W'(WIN))
        else $error("point count beyond window");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.den_calc |-> r_nq >= NQ_W'(r_ss))
        else $error("regression denominator negative");
    a_mean_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ddone && !r_dsel) |-> w_quo[DVD_W-1:SMP_W] == '0)
        else $error("mean wider than a sample");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || i_m_tready))
        else $error("output register overwritten");
`endif
endmodule

@@ src/ist_ctrl.sv @@
// controller: sequences one request through step, mean, regression and output
module ist_ctrl import ist_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_DGO   = 4'd2;
    localparam logic [3:0] S_DWAIT = 4'd3;
    localparam logic [3:0] S_POINT = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_TLAT  = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_MULT  = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_MGO   = 4'd10;
    localparam logic [3:0] S_MWAIT = 4'd11;
    localparam logic [3:0] S_DEN   = 4'd12;
    localparam logic [3:0] S_DCHK  = 4'd13;
    localparam logic [3:0] S_MAG   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0]      r_state, n_state;
    logic [MS_W-1:0] r_msel, n_msel;
    logic            r_sdiv, n_sdiv;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_msel  = r_msel;
        n_sdiv  = r_sdiv;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.point_due) begin
                    n_sdiv  = 1'b0;
                    n_state = S_DGO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = r_sdiv ? S_OUT : S_POINT;
                end
            end
            S_POINT: begin
                if (i_stat.skip_nz) begin
                    o_cmd.skip_dec = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.store = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.few) begin
                    o_cmd.slope_zero = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.tref_rd = 1'b1;
                    n_state       = S_TLAT;
                end
            end
            S_TLAT: begin
                o_cmd.tref_lat = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                o_cmd.pt_rd = 1'b1;
                n_state     = S_MULT;
            end
            S_MULT: begin
                o_cmd.pt_mul = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.pt_acc = 1'b1;
                if (i_stat.loop_last) begin
                    n_msel  = MS_NQ;
                    n_state = S_MGO;
                end else begin
                    n_state = S_RD;
                end
            end
            S_MGO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_stat.mul_done) begin
                    case (r_msel)
                        MS_NQ: begin
                            n_msel  = MS_SS;
                            n_state = S_MGO;
                        end
                        MS_SS: n_state = S_DEN;
                        MS_NP: begin
                            n_msel  = MS_SV;
                            n_state = S_MGO;
                        end
                        MS_SV: n_state = S_MAG;
                        default: begin
                            n_sdiv  = 1'b1;
                            n_state = S_DGO;
                        end
                    endcase
                end
            end
            S_DEN: begin
                o_cmd.den_calc = 1'b1;
                n_state        = S_DCHK;
            end
            S_DCHK: begin
                if (i_stat.den_zero) begin
                    o_cmd.slope_zero = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    n_msel  = MS_NP;
                    n_state = S_MGO;
                end
            end
            S_MAG: begin
                o_cmd.mag_calc = 1'b1;
                n_msel         = MS_SC;
                n_state        = S_MGO;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.mul_sel   = r_msel;
        o_cmd.div_slope = r_sdiv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_msel  <= MS_NQ;
            r_sdiv  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_msel  <= n_msel;
            r_sdiv  <= n_sdiv;
        end
    end

    assign o_s_tready = r_state == S_IDLE;
endmodule

@@ src/integrator_slope_tracker.sv @@
// top level: integrator slope tracker with stream ports and config write port
//
// Input channel (i_s_*) takes one request per transfer: a converter sample or,
// with tuser set, an external reset request, each with a microsecond timestamp.
// Output channel (o_m_*) returns exactly one status word per request, in order.
// Registers are written by the user through i_cfg_we/i_cfg_idx/i_cfg_data
// only while idle; the block itself does not enforce this. A request that
// forms no point is evaluated and its result then loaded into the output
// register. A point costs a mean division; a stored point also walks the ring
// and runs up to five serial multiplies and a slope division.
// These serial units set the rate: one request in flight at a time, the next
// one taken once the result is in the output register.
// A stalled receiver holds the result in the output register; one further
// request can be worked on meanwhile and waits to load until it drains.
// Reset (synchronous, active low) restores the default registers, empties the
// point window, and arms the first sample to open the accumulation.
module integrator_slope_tracker import ist_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [ID_W-1:0]   i_s_tdata,   // sample_raw, time_us, ceiling_hit
    input  logic              i_s_tuser,   // func
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // reset_drive, settling, new_point, slope_fixed, points_held, reset_event,
    // trip_raw, resets_done, discharge_stuck, latest_raw
    output logic [OD_W-1:0]   o_m_tdata,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;

    ist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    ist_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );
endmodule

@@ tb/sv/integrator_slope_tracker_checker.sv @@
// checker for the integrator slope tracker: predicts each status word and compares it
module integrator_slope_tracker_checker import ist_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [ID_W-1:0]   i_s_tdata,   // sample_raw, time_us, ceiling_hit
    input  logic              i_s_tuser,   // func
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    // reset_drive, settling, new_point, slope_fixed, points_held, reset_event,
    // trip_raw, resets_done, discharge_stuck, latest_raw
    input  logic [OD_W-1:0]   i_m_tdata,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OD_W-OD_BITS-1:0] pad;
        logic [11:0] latest_raw;
        logic        stuck;
        logic [31:0] resets_done;
        logic [11:0] trip_raw;
        logic        reset_event;
        logic [4:0]  points_held;
        logic [31:0] slope;
        logic        new_point;
        logic        settling;
        logic        reset_drive;
    } t_status;

    // register copies
    logic [11:0] sat_lvl, tgt_lvl;
    logic [19:0] period, timeout, settle;
    logic [3:0]  skip_cfg;

    // tracker state
    logic [1:0]  phase;
    logic [31:0] phase_t0, acc_t0, acc_sum, slope_q, resets;
    logic        start_pending, stuck_q;
    logic [19:0] acc_cnt;
    logic [31:0] pt_time [WIN];
    logic [11:0] pt_val [WIN];
    logic [4:0]  pt_total;
    logic [3:0]  wr_idx, skip_left;
    logic [11:0] last_smp, trip_q;

    t_status status_q[$];

    function automatic logic [31:0] fit_slope();
        bit [31:0]  tref, r;
        bit [63:0]  s, v, p, np, sv, mag;
        bit [127:0] q, d, quo, lim;
        bit         neg;
        s = 0; v = 0; p = 0; q = 0;
        if (pt_total < 2) return 0;
        tref = pt_time[(pt_total < WIN) ? 0 : wr_idx];
        for (int i = 0; i < pt_total; i++) begin
            r = pt_time[i] - tref;
            s += r;
            v += pt_val[i];
            p += 64'(r) * 64'(pt_val[i]);
            q += 128'(r) * 128'(r);
        end
        d = q * 128'(pt_total) - 128'(s) * 128'(s);
        if (d == 0) return 0;
        np = p * pt_total;
        sv = s * v;
        neg = np < sv;
        mag = neg ? sv - np : np - sv;
        quo = (128'(mag) * 128'd256000000) / d;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (quo > lim) quo = lim;
        return neg ? 32'(0) - quo[31:0] : quo[31:0];
    endfunction

    function automatic void start_reset(logic [31:0] t, logic [11:0] trip);
        trip_q = trip;
        phase = PH_DIS;
        phase_t0 = t;
        resets++;
    endfunction

    function automatic t_status track(logic func, logic [11:0] smp, logic [31:0] t,
                                      logic ceil);
        t_status res;
        logic    ev, np;
        logic [31:0] mean;
        ev = 0; np = 0;
        if (phase != PH_RUN) begin
            if (phase == PH_DIS) begin
                if (t - phase_t0 >= 32'(timeout)) begin
                    stuck_q = 1; phase = PH_SET; phase_t0 = t;
                end else if (!func && smp <= tgt_lvl) begin
                    stuck_q = 0; phase = PH_SET; phase_t0 = t;
                end
            end
            if (phase == PH_SET && t - phase_t0 >= 32'(settle)) begin
                pt_total = 0; wr_idx = 0; acc_sum = 0; acc_cnt = 0;
                acc_t0 = t; start_pending = 0; skip_left = skip_cfg;
                phase = PH_RUN;
            end
        end else if (func) begin
            start_reset(t, last_smp);
            ev = 1;
        end else begin
            last_smp = smp;
            if (start_pending) begin
                acc_t0 = t; start_pending = 0;
            end
            if (acc_cnt != COUNT_MAX) begin
                acc_sum += smp; acc_cnt++;
            end
            if (t - acc_t0 >= 32'(period)) begin
                mean = acc_sum / acc_cnt;
                if (skip_left != 0) skip_left--;
                else begin
                    pt_time[wr_idx] = t;
                    pt_val[wr_idx] = mean[11:0];
                    wr_idx++;
                    if (pt_total < WIN) pt_total++;
                    slope_q = fit_slope();
                    np = 1;
                end
                acc_sum = 0; acc_cnt = 0; acc_t0 = t;
            end
            if (smp >= sat_lvl || ceil) begin
                start_reset(t, smp);
                ev = 1;
            end
        end
        res = '0;
        res.reset_drive = phase == PH_DIS;
        res.settling = phase == PH_SET;
        res.new_point = np;
        res.slope = slope_q;
        res.points_held = pt_total;
        res.reset_event = ev;
        res.trip_raw = trip_q;
        res.resets_done = resets;
        res.stuck = stuck_q;
        res.latest_raw = last_smp;
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_waiting = status_q.size();

    always @(posedge i_clk) begin
        t_status got, want;
        if (!i_rst_n) begin
            sat_lvl <= 12'd4095; tgt_lvl <= 12'd620; period <= 20'd20000;
            timeout <= 20'd50000; settle <= 20'd20000; skip_cfg <= 4'd2;
            phase = PH_RUN; phase_t0 = 0; start_pending = 1; acc_sum = 0;
            acc_cnt = 0; acc_t0 = 0; pt_total = 0; wr_idx = 0; skip_left = 2;
            slope_q = 0; last_smp = 0; trip_q = 0; resets = 0; stuck_q = 0;
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAT:  sat_lvl <= i_cfg_data[11:0];
                    CFG_TGT:  tgt_lvl <= i_cfg_data[11:0];
                    CFG_PER:  period <= i_cfg_data;
                    CFG_TMO:  timeout <= i_cfg_data;
                    CFG_STL:  settle <= i_cfg_data;
                    CFG_SKIP: skip_cfg <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                status_q.push_back(track(i_s_tuser, i_s_tdata[11:0], i_s_tdata[43:12],
                                         i_s_tdata[44]));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (status_q.size() == 0) begin
                    $display("unexpected status word at %0t", $realtime);
                    o_errors++;
                end else begin
                    want = status_q.pop_front();
                    if (got.reset_drive != want.reset_drive)
                        report("reset_drive", got.reset_drive, want.reset_drive);
                    if (got.settling != want.settling)
                        report("settling", got.settling, want.settling);
                    if (got.new_point != want.new_point)
                        report("new_point", got.new_point, want.new_point);
                    if (got.slope != want.slope)
                        report("slope_fixed", got.slope, want.slope);
                    if (got.points_held != want.points_held)
                        report("points_held", got.points_held, want.points_held);
                    if (got.reset_event != want.reset_event)
                        report("reset_event", got.reset_event, want.reset_event);
                    if (got.trip_raw != want.trip_raw)
                        report("trip_raw", got.trip_raw, want.trip_raw);
                    if (got.resets_done != want.resets_done)
                        report("resets_done", got.resets_done, want.resets_done);
                    if (got.stuck != want.stuck)
                        report("discharge_stuck", got.stuck, want.stuck);
                    if (got.latest_raw != want.latest_raw)
                        report("latest_raw", got.latest_raw, want.latest_raw);
                end
            end
        end
    end

endmodule

@@ tb/sv/integrator_slope_tracker_test.sv @@
// testbench top for the integrator slope tracker: stimulus, phases and verdict
module integrator_slope_tracker_test;
    import ist_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 6_000_000;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_s_tvalid = 0;
    logic              o_s_tready;
    logic [ID_W-1:0]   i_s_tdata = '0;
    logic              i_s_tuser = 0;
    logic              o_m_tvalid;
    logic              i_m_tready = 0;
    logic [OD_W-1:0]   o_m_tdata;
    logic              i_cfg_we = 0;
    logic [CIDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    int errors, waiting, cycles;
    int send_idle = 0, recv_idle = 0, sent = 0;
    logic [31:0] now;
    logic [11:0] sat_now;

    integrator_slope_tracker dut (.*);

    integrator_slope_tracker_checker chk (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_waiting(waiting)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle);
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("integrator_slope_tracker test failed");
            $finish;
        end
    end
    initial cycles = 0;

    // one request, waits until the block takes it
    task automatic send_req(logic func, logic [11:0] smp, logic [31:0] t, logic ceil);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= func;
        i_s_tdata <= {3'b0, ceil, t, smp};
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        sent++;
        send_idle = (sent < 700) ? 7 : (sent < 1400) ? 51 : 0;
        recv_idle = (sent < 700) ? 51 : (sent < 1400) ? 7 : 0;
    endtask

    task automatic sample_at(int dt, logic [11:0] smp, logic ceil = 0);
        now += dt;
        send_req(0, smp, now, ceil);
    endtask

    task automatic set_regs(int sat, int tgt, int per, int tmo, int stl, int skp);
        i_s_tvalid <= 0;
        wait (waiting == 0);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= CFG_SAT; i_cfg_data <= 20'(sat); @(posedge i_clk);
        i_cfg_idx <= CFG_TGT;  i_cfg_data <= 20'(tgt); @(posedge i_clk);
        i_cfg_idx <= CFG_PER;  i_cfg_data <= 20'(per); @(posedge i_clk);
        i_cfg_idx <= CFG_TMO;  i_cfg_data <= 20'(tmo); @(posedge i_clk);
        i_cfg_idx <= CFG_STL;  i_cfg_data <= 20'(stl); @(posedge i_clk);
        i_cfg_idx <= CFG_SKIP; i_cfg_data <= 20'(skp); @(posedge i_clk);
        i_cfg_we <= 0;
        sat_now = 12'(sat);
    endtask

    task automatic random_reqs(int count, int step);
        int r;
        logic [11:0] smp;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            case ($urandom_range(9))
                0:       smp = $urandom_range(4095, (sat_now > 3900) ? sat_now : 3900);
                1, 2, 3: smp = $urandom_range(700);
                default: smp = $urandom_range(4095);
            endcase
            if (r < 5) now += $urandom;
            else if (r < 10) now += 0;
            else now += $urandom_range(step);
            send_req(r >= 95 && r < 98, smp, now, r >= 92 && r < 95);
        end
    endtask

    initial begin
        sat_now = 12'd4095;
        now = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults: first sample opens the window, two skipped points, then a slope
        sample_at(0, 12'd100);
        sample_at(10000, 12'd0);
        sample_at(10000, 12'd4094);
        for (int i = 0; i < 6; i++) sample_at(10000, 12'(200 + 300 * i));
        // external request, discharge released by a low sample, then settle
        send_req(1, 12'd0, now + 5, 0);
        now += 5;
        sample_at(100, 12'd3000);
        sample_at(100, 12'd620);
        sample_at(19999, 12'd50);
        sample_at(1, 12'd60);
        // ceiling together with a request, then discharge times out stuck
        send_req(1, 12'd10, now + 5, 1);
        now += 5;
        sample_at(30000, 12'd4000);
        sample_at(20000, 12'd4000);
        sample_at(20000, 12'd4000);
        // saturating sample, released and settled across the time wrap
        sample_at(100, 12'd4095);
        now = 32'hffff_ff00;
        sample_at(0, 12'd621);
        sample_at(50000, 12'd1);
        random_reqs(380, 12000);

        set_regs(3000, 1000, 300, 2000, 500, 0);
        random_reqs(400, 120);
        set_regs(4095, 0, 1, 1, 0, 15);
        random_reqs(400, 3);
        set_regs(0, 4095, 1000000, 1000000, 1000000, 1);
        random_reqs(100, 400000);
        // zero period and timeout
        set_regs(2500, 620, 0, 0, 0, 3);
        random_reqs(300, 50);
        set_regs(3800, 800, 2000, 20000, 3000, 2);
        random_reqs(400, 700);

        i_s_tvalid <= 0;
        wait (waiting == 0);
        repeat (500) @(posedge i_clk);
        if (errors == 0)
            $display("integrator_slope_tracker test passed");
        else
            $display("integrator_slope_tracker test failed");
        $finish;
    end

endmodule
